// ===== design/mlsep_pkg.sv =====
// ---------------------------------------------------------------------------
// MIDI-like sequence event parser: shared package
// Event codes, status constants, result record and queue sizing used by the
// parser core, the result queue and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlsep_pkg;

  // Byte position counter width; positions wrap at this many bits
  localparam int POSITION_BITS = 24;
  // Width in which positions are reported on the result channel
  localparam int REPORT_BITS   = 24;

  // Result queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS  = QUEUE_BITS + 1;

  typedef enum logic [3:0] {
    EV_NOTE_ON       = 4'd0,
    EV_NOTE_OFF      = 4'd1,
    EV_IMPLICIT_PROG = 4'd2,
    EV_PROGRAM       = 4'd3,
    EV_CONTROLLER    = 4'd4,
    EV_BEND          = 4'd5,
    EV_TEMPO         = 4'd6,
    EV_END           = 4'd7,
    EV_LOOP_START    = 4'd8,
    EV_LOOP_END      = 4'd9,
    EV_UNKNOWN_META  = 4'd10,
    EV_UNKNOWN       = 4'd11
  } event_code_t;

  // Status classes (upper nibble of a status byte)
  localparam logic [3:0] CLASS_NOTE    = 4'h9;
  localparam logic [3:0] CLASS_CONTROL = 4'hB;
  localparam logic [3:0] CLASS_PROGRAM = 4'hC;
  localparam logic [3:0] CLASS_BEND    = 4'hE;

  localparam logic [7:0] STATUS_META = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_END    = 8'h2F;
  localparam logic [3:0] META_CHANNEL = 4'hF;

  // Loop markers carried on a controller
  localparam logic [7:0] LOOP_CONTROLLER  = 8'd99;
  localparam logic [7:0] LOOP_START_VALUE = 8'd20;
  localparam logic [7:0] LOOP_END_VALUE   = 8'd30;

  typedef struct packed {
    event_code_t             code;
    logic [3:0]              channel;
    logic [31:0]             stamp;
    logic [7:0]              data1;
    logic [7:0]              data2;
    logic [23:0]             tempo;
    logic [REPORT_BITS-1:0]  loop_target;
    logic [REPORT_BITS-1:0]  position;
    logic                    last;
  } result_t;

  // Results produced by one transfer on the byte channel
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } push_t;

  function automatic logic channel_class(input logic [3:0] cls);
    return (cls == CLASS_NOTE) || (cls == CLASS_CONTROL) ||
           (cls == CLASS_PROGRAM) || (cls == CLASS_BEND);
  endfunction

endpackage

// ===== design/mlsep_if.sv =====
// ---------------------------------------------------------------------------
// MIDI-like sequence event parser: channel interfaces
// Valid/ready channels for stream bytes in and decoded events out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mlsep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mlsep_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [3:0]  channel_number;
  logic [31:0] event_time;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [23:0] tempo_value;
  logic [23:0] loop_target;
  logic [23:0] event_position;
  logic        last_of_run;

  modport source (output valid, output event_code, output channel_number,
                  output event_time, output first_data, output second_data,
                  output tempo_value, output loop_target, output event_position,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_code, input channel_number,
                  input event_time, input first_data, input second_data,
                  input tempo_value, input loop_target, input event_position,
                  input last_of_run, output ready);
endinterface

// ===== design/mlsep_core.sv =====
// ---------------------------------------------------------------------------
// MIDI-like sequence event parser: parser core
// Holds the parse state and decodes one byte per cycle, when a byte is taken,
// into up to two result records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlsep_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          stream_byte,
  output mlsep_pkg::push_t    push,
  output logic                stopped
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META,
    PH_TEMPO0, PH_TEMPO1, PH_TEMPO2, PH_STOP
  } phase_t;

  phase_t                               phase, phase_next;
  logic [7:0]                           running_status, running_status_next;
  logic [27:0]                          delta_acc, delta_acc_next;
  logic [31:0]                          tick_time, tick_time_next;
  logic [15:0]                          prog_mask, prog_mask_next;
  logic [mlsep_pkg::POSITION_BITS-1:0]  byte_pos, byte_pos_next, pos_inc;
  logic [mlsep_pkg::POSITION_BITS-1:0]  event_start, event_start_next;
  logic [mlsep_pkg::POSITION_BITS-1:0]  loop_start, loop_start_next;
  logic [7:0]                           held_byte, held_byte_next;
  logic [23:0]                          tempo_acc, tempo_acc_next;

  logic                                 do_first, do_meta, do_finish, do_stop;
  mlsep_pkg::event_code_t               stop_code;
  logic [3:0]                           stop_chan;
  logic [3:0]                           chan;
  logic [27:0]                          delta_shift;
  mlsep_pkg::result_t                   blank, res_a, res_b;
  logic [1:0]                           count;

  assign chan        = running_status[3:0];
  assign delta_shift = {delta_acc[20:0], stream_byte[6:0]};
  assign pos_inc     = byte_pos + mlsep_pkg::POSITION_BITS'(1);
  assign stopped     = (phase == PH_STOP);

  // Result record with the fields that every event shares
  always_comb begin
    blank             = '0;
    blank.code        = mlsep_pkg::EV_UNKNOWN;
    blank.stamp       = tick_time;
    blank.position    = mlsep_pkg::REPORT_BITS'(event_start);
  end

  // Decode one byte and work out the next state
  always_comb begin
    phase_next          = phase;
    running_status_next = running_status;
    delta_acc_next      = delta_acc;
    tick_time_next      = tick_time;
    prog_mask_next      = prog_mask;
    byte_pos_next       = byte_pos;
    event_start_next    = event_start;
    loop_start_next     = loop_start;
    held_byte_next      = held_byte;
    tempo_acc_next      = tempo_acc;
    do_first            = 1'b0;
    do_meta             = 1'b0;
    do_finish           = 1'b0;
    do_stop             = 1'b0;
    stop_code           = mlsep_pkg::EV_UNKNOWN;
    stop_chan           = chan;
    res_a               = blank;
    res_b               = blank;
    count               = 2'd0;

    if (take && phase != PH_STOP) begin
      byte_pos_next = pos_inc;
      unique case (phase)
        PH_DELTA: begin
          if (!stream_byte[7]) begin
            tick_time_next = tick_time + 32'(delta_shift);
            delta_acc_next = '0;
            phase_next     = PH_STATUS;
          end else begin
            delta_acc_next = delta_shift;
          end
        end
        PH_STATUS: begin
          if (stream_byte[7]) begin
            running_status_next = stream_byte;
            if (mlsep_pkg::channel_class(stream_byte[7:4])) begin
              phase_next = PH_DATA1;
            end else if (stream_byte == mlsep_pkg::STATUS_META) begin
              phase_next = PH_META;
            end else begin
              do_stop   = 1'b1;
              stop_chan = stream_byte[3:0];
            end
          end else if (mlsep_pkg::channel_class(running_status[7:4])) begin
            do_first = 1'b1;
          end else if (running_status == mlsep_pkg::STATUS_META) begin
            do_meta = 1'b1;
          end else begin
            do_stop = 1'b1;
          end
        end
        PH_DATA1: do_first = 1'b1;
        PH_DATA2: begin
          res_a.channel = chan;
          res_a.data1   = held_byte;
          res_a.data2   = stream_byte;
          count         = 2'd1;
          do_finish     = 1'b1;
          if (running_status[7:4] == mlsep_pkg::CLASS_NOTE) begin
            if (stream_byte != 8'd0) begin
              res_a.code = mlsep_pkg::EV_NOTE_ON;
              // Emit an implicit program change ahead of the first note on
              if (!prog_mask[chan]) begin
                res_b            = res_a;
                res_a            = blank;
                res_a.code       = mlsep_pkg::EV_IMPLICIT_PROG;
                res_a.channel    = chan;
                prog_mask_next   = prog_mask | (16'd1 << chan);
                count            = 2'd2;
              end
            end else begin
              res_a.code  = mlsep_pkg::EV_NOTE_OFF;
              res_a.data2 = 8'd0;
            end
          end else if (running_status[7:4] == mlsep_pkg::CLASS_CONTROL) begin
            if (held_byte == mlsep_pkg::LOOP_CONTROLLER &&
                stream_byte == mlsep_pkg::LOOP_START_VALUE) begin
              res_a.code        = mlsep_pkg::EV_LOOP_START;
              res_a.loop_target = mlsep_pkg::REPORT_BITS'(pos_inc);
              loop_start_next   = pos_inc;
            end else if (held_byte == mlsep_pkg::LOOP_CONTROLLER &&
                         stream_byte == mlsep_pkg::LOOP_END_VALUE) begin
              res_a.code        = mlsep_pkg::EV_LOOP_END;
              res_a.loop_target = mlsep_pkg::REPORT_BITS'(loop_start);
              // Jump back to the recorded loop start
              if (loop_start != '0) begin
                byte_pos_next = loop_start;
              end
            end else begin
              res_a.code = mlsep_pkg::EV_CONTROLLER;
            end
          end else begin
            res_a.code = mlsep_pkg::EV_BEND;
          end
        end
        PH_META: do_meta = 1'b1;
        PH_TEMPO0: begin
          tempo_acc_next = {tempo_acc[15:0], stream_byte};
          phase_next     = PH_TEMPO1;
        end
        PH_TEMPO1: begin
          tempo_acc_next = {tempo_acc[15:0], stream_byte};
          phase_next     = PH_TEMPO2;
        end
        PH_TEMPO2: begin
          tempo_acc_next = {tempo_acc[15:0], stream_byte};
          res_a.code     = mlsep_pkg::EV_TEMPO;
          res_a.channel  = mlsep_pkg::META_CHANNEL;
          res_a.tempo    = {tempo_acc[15:0], stream_byte};
          count          = 2'd1;
          do_finish      = 1'b1;
        end
        default: phase_next = PH_STOP;
      endcase
    end

    // First data byte: program change completes, anything else waits
    if (do_first) begin
      if (running_status[7:4] == mlsep_pkg::CLASS_PROGRAM) begin
        res_a.code     = mlsep_pkg::EV_PROGRAM;
        res_a.channel  = chan;
        res_a.data1    = stream_byte;
        prog_mask_next = prog_mask | (16'd1 << chan);
        count          = 2'd1;
        do_finish      = 1'b1;
      end else begin
        held_byte_next = stream_byte;
        phase_next     = PH_DATA2;
      end
    end

    // Meta type byte
    if (do_meta) begin
      stop_chan = mlsep_pkg::META_CHANNEL;
      if (stream_byte == mlsep_pkg::META_TEMPO) begin
        tempo_acc_next = '0;
        phase_next     = PH_TEMPO0;
      end else if (stream_byte == mlsep_pkg::META_END) begin
        do_stop   = 1'b1;
        stop_code = mlsep_pkg::EV_END;
      end else begin
        do_stop   = 1'b1;
        stop_code = mlsep_pkg::EV_UNKNOWN_META;
      end
    end

    // Report and halt
    if (do_stop) begin
      res_a.code    = stop_code;
      res_a.channel = stop_chan;
      count         = 2'd1;
      phase_next    = PH_STOP;
    end

    // Close the event: next delta starts here
    if (do_finish) begin
      phase_next       = PH_DELTA;
      event_start_next = byte_pos_next;
    end

    if (count == 2'd1) begin
      res_a.last = 1'b1;
    end
    if (count == 2'd2) begin
      res_b.last = 1'b1;
    end
  end

  assign push.count = count;
  assign push.res_a = res_a;
  assign push.res_b = res_b;

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      running_status <= '0;
      delta_acc      <= '0;
      tick_time      <= '0;
      prog_mask      <= '0;
      byte_pos       <= '0;
      event_start    <= '0;
      loop_start     <= '0;
      held_byte      <= '0;
      tempo_acc      <= '0;
    end else begin
      phase          <= phase_next;
      running_status <= running_status_next;
      delta_acc      <= delta_acc_next;
      tick_time      <= tick_time_next;
      prog_mask      <= prog_mask_next;
      byte_pos       <= byte_pos_next;
      event_start    <= event_start_next;
      loop_start     <= loop_start_next;
      held_byte      <= held_byte_next;
      tempo_acc      <= tempo_acc_next;
    end
  end

endmodule

// ===== design/mlsep_queue.sv =====
// ---------------------------------------------------------------------------
// MIDI-like sequence event parser: result queue
// Small register queue that takes up to two results a cycle and hands one
// result a cycle, when popped, to the output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlsep_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  mlsep_pkg::push_t                   push,
  input  logic                               pop,
  output mlsep_pkg::result_t                 head,
  output logic [mlsep_pkg::LEVEL_BITS-1:0]   level
);

  mlsep_pkg::result_t                   slots [mlsep_pkg::QUEUE_DEPTH];
  logic [mlsep_pkg::QUEUE_BITS-1:0]     wr_ptr, rd_ptr;
  logic [mlsep_pkg::QUEUE_BITS-1:0]     wr_ptr_b;

  assign wr_ptr_b = wr_ptr + mlsep_pkg::QUEUE_BITS'(1);
  assign head     = slots[rd_ptr];

  // Write incoming results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.res_a;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_b] <= push.res_b;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mlsep_pkg::QUEUE_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + mlsep_pkg::QUEUE_BITS'(1);
      end
      level <= level + mlsep_pkg::LEVEL_BITS'(push.count)
                     - mlsep_pkg::LEVEL_BITS'(pop);
    end
  end

endmodule

// ===== design/midi_like_sequence_event_parser.sv =====
// ---------------------------------------------------------------------------
// MIDI-like sequence event parser
// Decodes delta times, running status, channel and meta events from a byte
// stream and reports one event record per transfer on the result channel.
// ---------------------------------------------------------------------------
// Results are registered in the result queue and offered from its head.
// Throughput: one byte per cycle while the byte channel is ready; a byte
// with two results drains them one at a time through a four-entry result
// queue, and the byte channel is ready while two or more entries are free.
// Reset: synchronous, active high; clears parse state and empties the
// queue. After end of track or an unknown event bytes are dropped until reset.
`timescale 1ns / 1ps

module midi_like_sequence_event_parser (
  input  logic                  clk,
  input  logic                  rst,
  mlsep_byte_if.sink            stream,
  mlsep_event_if.source         events
);

  mlsep_pkg::push_t                    push;
  mlsep_pkg::result_t                  head;
  logic [mlsep_pkg::LEVEL_BITS-1:0]    level;
  logic                                stopped;
  logic                                take;
  logic                                pop;

  // Accept while at least two queue entries are free
  assign stream.ready = (level <= mlsep_pkg::LEVEL_BITS'(mlsep_pkg::QUEUE_DEPTH - 2));
  assign take         = stream.valid && stream.ready;
  assign pop          = events.valid && events.ready;

  mlsep_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .stream_byte (stream.stream_byte),
    .push        (push),
    .stopped     (stopped)
  );

  mlsep_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  // Drive the result channel from the queue head
  assign events.valid          = (level != '0);
  assign events.event_code     = head.code;
  assign events.channel_number = head.channel;
  assign events.event_time     = head.stamp;
  assign events.first_data     = head.data1;
  assign events.second_data    = head.data2;
  assign events.tempo_value    = head.tempo;
  assign events.loop_target    = head.loop_target;
  assign events.event_position = head.position;
  assign events.last_of_run    = head.last;

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    level <= mlsep_pkg::LEVEL_BITS'(mlsep_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A stopped parser produces nothing
  assert property (@(posedge clk) disable iff (rst)
    stopped |-> (push.count == 2'd0))
    else $error("result produced after stop");

  // A pair of results is always implicit program then the closing note on
  assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.res_a.code == mlsep_pkg::EV_IMPLICIT_PROG &&
                              !push.res_a.last && push.res_b.last))
    else $error("malformed result pair");

  // Bytes taken only with room for two results
  assert property (@(posedge clk) disable iff (rst)
    take |=> (level <= mlsep_pkg::LEVEL_BITS'(mlsep_pkg::QUEUE_DEPTH)))
    else $error("byte taken without queue room");

endmodule

// ===== dv/midi_like_sequence_event_parser_tb.sv =====
// ---------------------------------------------------------------------------
// MIDI-like sequence event parser: self-checking testbench
// Feeds a byte stream of delta times, voice events, tempo and loop markers,
// with and without running status, through the byte channel under random
// bursts and gaps. The event channel stalls on patterns of its own. Every
// decoded event is checked field by field against a cycle-free decoder
// kept in step with the accepted bytes. The stream ends with one stopping
// event and a tail of bytes that the parser must drop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_like_sequence_event_parser_tb;
  import mlsep_pkg::*;

  localparam int STREAM_BYTES = 1500;
  localparam int DRAIN_EVERY  = 250;
  localparam int SETTLE_CYCLES = 8;

  // Status classes and system statuses that the parser rejects
  localparam logic [3:0] CLASS_KEY_OFF       = 4'h8;
  localparam logic [3:0] CLASS_KEY_PRESSURE  = 4'hA;
  localparam logic [3:0] CLASS_CHAN_PRESSURE = 4'hD;
  localparam logic [7:0] SYSTEM_FIRST        = 8'hF0;
  localparam logic [7:0] SYSTEM_LAST         = 8'hFE;

  typedef enum logic [3:0] {
    AWAIT_DELTA, AWAIT_STATUS, AWAIT_FIRST, AWAIT_SECOND, AWAIT_META,
    TEMPO_HI, TEMPO_MID, TEMPO_LO, HALTED
  } parse_phase_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKED} rx_mode_t;
  typedef enum int {HALT_END, HALT_META, HALT_VOICE, HALT_SYSTEM} halt_kind_t;

  typedef struct {
    logic [7:0] value;
    bit         hold_for_drain;
  } feed_item_t;

  logic clk;
  logic rst;

  mlsep_byte_if  stream_if ();
  mlsep_event_if event_if ();

  midi_like_sequence_event_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .events (event_if)
  );

  // Stimulus and expectation stores
  feed_item_t byte_feed_q [$];
  result_t    pending_events [$];
  bit         drained = 1'b1;

  // Decoder state
  parse_phase_t             phase;
  logic [7:0]               run_status;
  logic [27:0]              delta_acc;
  logic [31:0]              tick_count;
  logic [15:0]              prog_mask;
  logic [POSITION_BITS-1:0] byte_pos;
  logic [POSITION_BITS-1:0] event_origin;
  logic [POSITION_BITS-1:0] loop_pos;
  logic [7:0]               held_data;
  logic [23:0]              tempo_acc;
  bit                       halted;

  // Generator view of running status
  logic [7:0] gen_status;

  int  mismatches;
  int  bytes_taken;
  int  events_checked;
  bit  code_seen [12];
  string halt_how;

  // Driver and receiver bookkeeping
  feed_item_t next_item;
  int         gap_left;
  int         burst_left;
  rx_mode_t   rx_mode;
  int         seg_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Decoder
  // -------------------------------------------------------------------------
  function automatic result_t make_event(input event_code_t code, input logic [3:0] chan,
                                         input logic [7:0] d1, input logic [7:0] d2,
                                         input logic [23:0] tempo,
                                         input logic [23:0] loop_t);
    result_t r;
    r             = '0;
    r.code        = code;
    r.channel     = chan;
    r.stamp       = tick_count;
    r.data1       = d1;
    r.data2       = d2;
    r.tempo       = tempo;
    r.loop_target = loop_t;
    r.position    = REPORT_BITS'(event_origin);
    return r;
  endfunction

  function automatic result_t halt_event(input event_code_t code, input logic [3:0] chan);
    result_t r;
    r      = make_event(code, chan, 8'd0, 8'd0, 24'd0, 24'd0);
    halted = 1'b1;
    phase  = HALTED;
    return r;
  endfunction

  function automatic bit is_voice(input logic [3:0] cls);
    return cls == CLASS_NOTE || cls == CLASS_CONTROL || cls == CLASS_PROGRAM ||
           cls == CLASS_BEND;
  endfunction

  function automatic void close_event();
    phase        = AWAIT_DELTA;
    event_origin = byte_pos;
  endfunction

  task automatic decode_stream_byte(input logic [7:0] b);
    result_t      found [2];
    int           n;
    parse_phase_t route;
    logic [3:0]   chan;
    logic [3:0]   cls;
    n     = 0;
    route = AWAIT_STATUS;
    if (!halted) begin
      byte_pos = byte_pos + 1'b1;
      chan     = run_status[3:0];
      cls      = run_status[7:4];
      // Delta and status bytes; a data byte in status position reuses the status
      case (phase)
        AWAIT_DELTA: begin
          delta_acc = {delta_acc[20:0], b[6:0]};
          if (!b[7]) begin
            tick_count = tick_count + 32'(delta_acc);
            delta_acc  = '0;
            phase      = AWAIT_STATUS;
          end
        end
        AWAIT_STATUS: begin
          if (b[7]) begin
            run_status = b;
            if (is_voice(b[7:4])) begin
              phase = AWAIT_FIRST;
            end else if (b == STATUS_META) begin
              phase = AWAIT_META;
            end else begin
              found[0] = halt_event(EV_UNKNOWN, b[3:0]);
              n = 1;
            end
          end else if (is_voice(cls)) begin
            route = AWAIT_FIRST;
          end else if (run_status == STATUS_META) begin
            route = AWAIT_META;
          end else begin
            found[0] = halt_event(EV_UNKNOWN, chan);
            n = 1;
          end
        end
        default: route = phase;
      endcase
      // Data, meta type and tempo bytes
      case (route)
        AWAIT_FIRST: begin
          if (cls == CLASS_PROGRAM) begin
            found[0] = make_event(EV_PROGRAM, chan, b, 8'd0, 24'd0, 24'd0);
            prog_mask[chan] = 1'b1;
            n = 1;
            close_event();
          end else begin
            held_data = b;
            phase     = AWAIT_SECOND;
          end
        end
        AWAIT_SECOND: begin
          if (cls == CLASS_NOTE) begin
            if (b != 8'd0) begin
              if (!prog_mask[chan]) begin
                found[0] = make_event(EV_IMPLICIT_PROG, chan, 8'd0, 8'd0, 24'd0, 24'd0);
                prog_mask[chan] = 1'b1;
                n = 1;
              end
              found[n] = make_event(EV_NOTE_ON, chan, held_data, b, 24'd0, 24'd0);
              n++;
            end else begin
              found[0] = make_event(EV_NOTE_OFF, chan, held_data, 8'd0, 24'd0, 24'd0);
              n = 1;
            end
          end else if (cls == CLASS_CONTROL) begin
            if (held_data == LOOP_CONTROLLER && b == LOOP_START_VALUE) begin
              loop_pos = byte_pos;
              found[0] = make_event(EV_LOOP_START, chan, held_data, b, 24'd0,
                                    REPORT_BITS'(loop_pos));
            end else if (held_data == LOOP_CONTROLLER && b == LOOP_END_VALUE) begin
              found[0] = make_event(EV_LOOP_END, chan, held_data, b, 24'd0,
                                    REPORT_BITS'(loop_pos));
              // jump back to the recorded loop start
              if (loop_pos != '0) byte_pos = loop_pos;
            end else begin
              found[0] = make_event(EV_CONTROLLER, chan, held_data, b, 24'd0, 24'd0);
            end
            n = 1;
          end else begin
            found[0] = make_event(EV_BEND, chan, held_data, b, 24'd0, 24'd0);
            n = 1;
          end
          close_event();
        end
        AWAIT_META: begin
          if (b == META_TEMPO) begin
            tempo_acc = '0;
            phase     = TEMPO_HI;
          end else if (b == META_END) begin
            found[0] = halt_event(EV_END, META_CHANNEL);
            n = 1;
          end else begin
            found[0] = halt_event(EV_UNKNOWN_META, META_CHANNEL);
            n = 1;
          end
        end
        TEMPO_HI: begin
          tempo_acc = {tempo_acc[15:0], b};
          phase     = TEMPO_MID;
        end
        TEMPO_MID: begin
          tempo_acc = {tempo_acc[15:0], b};
          phase     = TEMPO_LO;
        end
        TEMPO_LO: begin
          tempo_acc = {tempo_acc[15:0], b};
          found[0]  = make_event(EV_TEMPO, META_CHANNEL, 8'd0, 8'd0, tempo_acc, 24'd0);
          n = 1;
          close_event();
        end
        default: ;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) found[i].last = 1'b1;
      pending_events.push_back(found[i]);
    end
  endtask

  // -------------------------------------------------------------------------
  // Stream generation
  // -------------------------------------------------------------------------
  function automatic void feed_byte(input logic [7:0] value, input bit hold);
    feed_item_t it;
    it.value          = value;
    it.hold_for_drain = hold;
    byte_feed_q.push_back(it);
  endfunction

  function automatic logic [7:0] pick_data(input bit wide);
    logic [7:0] top;
    top = wide ? 8'hFF : 8'h7F;
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return top;
      default: return 8'($urandom_range(0, top));
    endcase
  endfunction

  function automatic void feed_delta(input bit hold);
    int r;
    int len;
    bit full;
    r    = $urandom_range(0, 99);
    len  = r < 55 ? 1 : r < 80 ? 2 : r < 90 ? 3 : r < 97 ? 4 : $urandom_range(5, 6);
    full = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < len; k++) begin
      feed_byte({k != len - 1, full ? 7'h7F : 7'($urandom_range(0, 127))}, hold && k == 0);
    end
  endfunction

  function automatic void feed_event(input bit hold);
    int         kind;
    bit         noisy;
    logic [3:0] cls;
    logic [3:0] ch;
    logic [7:0] d1;
    logic [7:0] d2;
    feed_delta(hold);
    kind  = $urandom_range(0, 91);
    noisy = ($urandom_range(0, 9) == 0);
    if (kind < 82) begin
      cls = kind < 35 ? CLASS_NOTE : kind < 62 ? CLASS_CONTROL :
            kind < 72 ? CLASS_PROGRAM : CLASS_BEND;
      ch  = (gen_status[7:4] == cls && $urandom_range(0, 1)) ? gen_status[3:0]
                                                             : 4'($urandom_range(0, 15));
      d1  = pick_data(noisy);
      d2  = pick_data(noisy);
      if (cls == CLASS_NOTE && $urandom_range(0, 3) == 0) d2 = 8'd0;
      if (cls == CLASS_CONTROL && kind >= 50) begin
        d1 = LOOP_CONTROLLER;
        d2 = kind < 56 ? LOOP_START_VALUE : LOOP_END_VALUE;
      end
      // omit the status byte where running status allows it
      if (!(gen_status == {cls, ch} && !d1[7] && $urandom_range(0, 1))) begin
        feed_byte({cls, ch}, 1'b0);
        gen_status = {cls, ch};
      end
      feed_byte(d1, 1'b0);
      if (cls != CLASS_PROGRAM) feed_byte(d2, 1'b0);
    end else begin
      if (gen_status == STATUS_META && $urandom_range(0, 1)) begin
        feed_byte(META_TEMPO, 1'b0);
      end else begin
        feed_byte(STATUS_META, 1'b0);
        feed_byte(META_TEMPO, 1'b0);
        gen_status = STATUS_META;
      end
      repeat (3) feed_byte(pick_data(1'b1), 1'b0);
    end
  endfunction

  // Close the stream with one stopping event, then bytes that must be dropped
  function automatic void feed_halt();
    halt_kind_t kind;
    logic [7:0] v;
    int         pick;
    feed_delta(1'b0);
    kind = halt_kind_t'($urandom_range(0, 3));
    case (kind)
      HALT_END: begin
        feed_byte(STATUS_META, 1'b0);
        feed_byte(META_END, 1'b0);
        halt_how = "end of track";
      end
      HALT_META: begin
        v = 8'($urandom_range(0, 255));
        while (v == META_TEMPO || v == META_END) v = 8'($urandom_range(0, 255));
        feed_byte(STATUS_META, 1'b0);
        feed_byte(v, 1'b0);
        halt_how = "unknown meta type";
      end
      HALT_VOICE: begin
        pick = $urandom_range(0, 2);
        feed_byte({pick == 0 ? CLASS_KEY_OFF : pick == 1 ? CLASS_KEY_PRESSURE
                                                          : CLASS_CHAN_PRESSURE,
                   4'($urandom_range(0, 15))}, 1'b0);
        halt_how = "unsupported channel status";
      end
      default: begin
        feed_byte(8'($urandom_range(SYSTEM_FIRST, SYSTEM_LAST)), 1'b0);
        halt_how = "system status";
      end
    endcase
    repeat ($urandom_range(4, 10)) feed_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // -------------------------------------------------------------------------
  // Byte driver: bursts with random gaps, hold at drain points
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else if (!stream_if.valid || stream_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        stream_if.valid <= 1'b0;
      end else if (byte_feed_q.size() == 0 ||
                   (byte_feed_q[0].hold_for_drain && !(drained && !stream_if.valid))) begin
        stream_if.valid <= 1'b0;
      end else begin
        next_item = byte_feed_q.pop_front();
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= next_item.value;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Event receiver: stall pattern changes every segment
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      event_if.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 3));
        seg_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 16) : $urandom_range(8, 64);
      end
      seg_left--;
      case (rx_mode)
        RX_OPEN:     event_if.ready <= 1'b1;
        RX_RANDOM:   event_if.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: event_if.ready <= (seg_left % 3 != 0);
        default:     event_if.ready <= 1'b0;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: decode accepted bytes, check accepted events
  // -------------------------------------------------------------------------
  function automatic void check_field(input string label, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", label, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (stream_if.valid && stream_if.ready) begin
        decode_stream_byte(stream_if.stream_byte);
        bytes_taken++;
      end
      if (event_if.valid && event_if.ready) begin
        if (pending_events.size() == 0) begin
          $error("event_code: expected none, got %0d", event_if.event_code);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_code",     32'(want.code),        32'(event_if.event_code));
          check_field("channel_number", 32'(want.channel),     32'(event_if.channel_number));
          check_field("event_time",     want.stamp,            event_if.event_time);
          check_field("first_data",     32'(want.data1),       32'(event_if.first_data));
          check_field("second_data",    32'(want.data2),       32'(event_if.second_data));
          check_field("tempo_value",    32'(want.tempo),       32'(event_if.tempo_value));
          check_field("loop_target",    32'(want.loop_target), 32'(event_if.loop_target));
          check_field("event_position", 32'(want.position),    32'(event_if.event_position));
          check_field("last_of_run",    32'(want.last),        32'(event_if.last_of_run));
          code_seen[want.code] = 1'b1;
          events_checked++;
        end
      end
      drained <= (pending_events.size() == 0);
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: build stream, reset, wait for drain, report
  // -------------------------------------------------------------------------
  initial begin
    int kinds;
    int next_drain;
    rst                   = 1'b1;
    stream_if.valid       = 1'b0;
    stream_if.stream_byte = 8'd0;
    event_if.ready        = 1'b0;
    phase        = AWAIT_DELTA;
    run_status   = '0;
    delta_acc    = '0;
    tick_count   = '0;
    prog_mask    = '0;
    byte_pos     = '0;
    event_origin = '0;
    loop_pos     = '0;
    held_data    = '0;
    tempo_acc    = '0;
    halted       = 1'b0;
    gen_status   = '0;
    gap_left     = 0;
    burst_left   = 0;
    seg_left     = 0;
    rx_mode      = RX_OPEN;
    mismatches   = 0;
    bytes_taken  = 0;
    events_checked = 0;

    // Implicit program then note on, channel 0
    feed_byte(8'h00, 1'b0); feed_byte({CLASS_NOTE, 4'h0}, 1'b0);
    feed_byte(8'h3C, 1'b0); feed_byte(8'h64, 1'b0);
    // Over-long delta, then loop start on channel 15
    repeat (4) feed_byte(8'hFF, 1'b0);
    feed_byte(8'h7F, 1'b0); feed_byte({CLASS_CONTROL, 4'hF}, 1'b0);
    feed_byte(LOOP_CONTROLLER, 1'b0); feed_byte(LOOP_START_VALUE, 1'b0);
    // Tempo, then tempo again on running meta status at full scale
    feed_byte(8'h00, 1'b0); feed_byte(STATUS_META, 1'b0); feed_byte(META_TEMPO, 1'b0);
    feed_byte(8'h07, 1'b0); feed_byte(8'hA1, 1'b0); feed_byte(8'h20, 1'b0);
    feed_byte(8'h00, 1'b0); feed_byte(META_TEMPO, 1'b0);
    repeat (3) feed_byte(8'hFF, 1'b0);
    // Loop end with a recorded start: position jumps back
    feed_byte(8'h00, 1'b0); feed_byte({CLASS_CONTROL, 4'h3}, 1'b0);
    feed_byte(LOOP_CONTROLLER, 1'b0); feed_byte(LOOP_END_VALUE, 1'b0);
    gen_status = {CLASS_CONTROL, 4'h3};

    next_drain = DRAIN_EVERY;
    while (byte_feed_q.size() < STREAM_BYTES) begin
      if (byte_feed_q.size() >= next_drain) begin
        feed_event(1'b1);
        next_drain += DRAIN_EVERY;
      end else begin
        feed_event(1'b0);
      end
    end
    feed_halt();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (byte_feed_q.size() != 0 || stream_if.valid || pending_events.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      mismatches += pending_events.size();
    end

    kinds = 0;
    foreach (code_seen[c]) kinds += code_seen[c];
    $display("Run covered %0d stream bytes, %0d events checked, %0d of 12 event kinds",
             bytes_taken, events_checked, kinds);
    $display("Stream closed by %s followed by dropped bytes", halt_how);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/mlsep_pkg.sv
design/mlsep_if.sv
design/mlsep_core.sv
design/mlsep_queue.sv
design/midi_like_sequence_event_parser.sv
dv/midi_like_sequence_event_parser_tb.sv
